// File: rtl/risc_subset_execute_unit_assert.svh
// Assertion macros for the execute unit checkers.
`ifndef RISC_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define RISC_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RSX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define RSX_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rsx_pkg.sv
// Shared widths, function codes and types of the execute unit.
package rsx_pkg;

   localparam int FUNC_W      = 4;
   localparam int DATA_W      = 32;
   localparam int REG_COUNT   = 32;
   localparam int REG_IDX_W   = 5;
   localparam int COUNT_W     = 32;
   localparam int NUM_OPS     = 10;
   localparam int OP_IDX_W    = 4;
   localparam int PC_OUT_W    = 10;
   localparam int ADDR_IN_W   = 12;
   localparam int TARGET_IN_W = 10;

   // Function codes of the request word.
   localparam logic [FUNC_W-1:0] FN_ADD     = 4'd1;
   localparam logic [FUNC_W-1:0] FN_SUB     = 4'd2;
   localparam logic [FUNC_W-1:0] FN_MUL     = 4'd3;
   localparam logic [FUNC_W-1:0] FN_ADDI    = 4'd4;
   localparam logic [FUNC_W-1:0] FN_BEQ     = 4'd5;
   localparam logic [FUNC_W-1:0] FN_BNE     = 4'd6;
   localparam logic [FUNC_W-1:0] FN_SLT     = 4'd7;
   localparam logic [FUNC_W-1:0] FN_LW      = 4'd8;
   localparam logic [FUNC_W-1:0] FN_SW      = 4'd9;
   localparam logic [FUNC_W-1:0] FN_J       = 4'd10;
   localparam logic [FUNC_W-1:0] FN_PRE_MEM = 4'd11;
   localparam logic [FUNC_W-1:0] FN_PRE_REG = 4'd12;

   // Register file write port.
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] addr;
      logic [DATA_W-1:0]    data;
   } rf_wr_type;

endpackage

// File: rtl/rsx_mod_const.sv
// Remainder of a narrow value by a constant divisor.
module rsx_mod_const #(
   parameter int IN_W    = 12,
   parameter int DIVISOR = 4096,
   parameter int OUT_W   = 12
) (
   input  logic [IN_W-1:0]  value,
   output logic [OUT_W-1:0] remainder
);

   generate
      if (DIVISOR >= (1 << IN_W)) begin : g_pass
         // Every input value is already below the divisor.
         assign remainder = OUT_W'(value);
      end else if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_mask
         // Power of two: keep the low bits.
         assign remainder = value[OUT_W-1:0];
      end else begin : g_recip
         localparam int SHIFT   = 2 * IN_W;
         localparam int RECIP_W = SHIFT + 1;
         localparam int PROD_W  = IN_W + RECIP_W;
         localparam logic [RECIP_W-1:0] RECIP =
            RECIP_W'(((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR);

         logic [PROD_W-1:0] product;
         logic [IN_W-1:0]   quotient;
         logic [IN_W-1:0]   partial;
         logic [IN_W-1:0]   diff;

         // Quotient by a scaled reciprocal, then one correction step.
         assign product   = PROD_W'(value) * PROD_W'(RECIP);
         assign quotient  = product[SHIFT +: IN_W];
         assign partial   = IN_W'(quotient * DIVISOR);
         assign diff      = value - partial;
         assign remainder = (diff >= IN_W'(DIVISOR)) ? OUT_W'(diff - IN_W'(DIVISOR))
                                                      : OUT_W'(diff);
      end
   endgenerate

endmodule

// File: rtl/rsx_regfile.sv
// Register file memory with two registered read ports, valid bits and write forwarding.
module rsx_regfile (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [rsx_pkg::REG_IDX_W-1:0]      rd_addr_a,
   input  logic [rsx_pkg::REG_IDX_W-1:0]      rd_addr_b,
   input  rsx_pkg::rf_wr_type                 wr,
   output logic [rsx_pkg::DATA_W-1:0]         rd_data_a,
   output logic [rsx_pkg::DATA_W-1:0]         rd_data_b
);

   logic [rsx_pkg::DATA_W-1:0]    mem [rsx_pkg::REG_COUNT];
   logic [rsx_pkg::DATA_W-1:0]    mem_a_ff;
   logic [rsx_pkg::DATA_W-1:0]    mem_b_ff;
   logic [rsx_pkg::REG_IDX_W-1:0] addr_a_ff;
   logic [rsx_pkg::REG_IDX_W-1:0] addr_b_ff;
   logic [rsx_pkg::REG_COUNT-1:0] valid_ff;
   logic [rsx_pkg::REG_COUNT-1:0] valid_in;
   logic                          fwd_valid_ff;
   logic                          fwd_valid_in;
   logic [rsx_pkg::REG_IDX_W-1:0] fwd_addr_ff;
   logic [rsx_pkg::DATA_W-1:0]    fwd_data_ff;

   // Storage write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read ports; data and address hold while no new word is taken.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_a_ff  <= mem[rd_addr_a];
         mem_b_ff  <= mem[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   // A register never written reads as zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   assign fwd_valid_in = fwd_valid_ff | wr.en;

   // Valid bits and the record of the latest write.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      if (wr.en) begin
         fwd_addr_ff <= wr.addr;
         fwd_data_ff <= wr.data;
      end
   end

   // The latest write wins over the array, which may have been read in the same cycle.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == addr_a_ff)) begin
         rd_data_a = fwd_data_ff;
      end else if (valid_ff[addr_a_ff]) begin
         rd_data_a = mem_a_ff;
      end else begin
         rd_data_a = '0;
      end
      if (fwd_valid_ff && (fwd_addr_ff == addr_b_ff)) begin
         rd_data_b = fwd_data_ff;
      end else if (valid_ff[addr_b_ff]) begin
         rd_data_b = mem_b_ff;
      end else begin
         rd_data_b = '0;
      end
   end

endmodule

// File: rtl/rsx_dmem.sv
// Data memory with a valid bit in each word, a clearing pass after reset and write forwarding.
module rsx_dmem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       busy,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic                       rd_valid,
   output logic [rsx_pkg::DATA_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [rsx_pkg::DATA_W-1:0] wr_data
);

   localparam int WORD_W = rsx_pkg::DATA_W + 1;

   logic [WORD_W-1:0]          mem [DEPTH];
   logic [WORD_W-1:0]          rd_word_ff;
   logic [AW-1:0]              rd_addr_ff;
   logic                       clear_ff;
   logic                       clear_in;
   logic [AW-1:0]              clear_addr_ff;
   logic [AW-1:0]              clear_addr_in;
   logic                       fwd_valid_ff;
   logic                       fwd_valid_in;
   logic [AW-1:0]              fwd_addr_ff;
   logic [rsx_pkg::DATA_W-1:0] fwd_data_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [WORD_W-1:0]          mem_wd;

   // The clearing pass owns the write port until every word is marked invalid.
   assign mem_we = clear_ff | wr_en;
   assign mem_wa = clear_ff ? clear_addr_ff : wr_addr;
   assign mem_wd = clear_ff ? WORD_W'(0) : {1'b1, wr_data};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Clearing pass sequence, one word a cycle.
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + AW'(1);
         if (clear_addr_ff == AW'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   assign fwd_valid_in = fwd_valid_ff | wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   assign busy = clear_ff;

   // A store in the same cycle as the read is taken from the write record.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         rd_valid = 1'b1;
         rd_data  = fwd_data_ff;
      end else begin
         rd_valid = rd_word_ff[rsx_pkg::DATA_W];
         rd_data  = rd_word_ff[rsx_pkg::DATA_W-1:0];
      end
   end

endmodule

// File: rtl/risc_subset_execute_unit.sv
// Top level of the execute unit: request stage, execute stage and result register.
//
//   channel | direction | words                        | handshake
//   req_    | in        | one pre-decoded instruction  | req_valid / req_ready
//   rsp_    | out       | one result per instruction   | rsp_valid / rsp_ready
//
// One instruction a cycle when rsp_ready stays high and the clearing pass is
// done; the limit is the registered read of the register file and data
// memory, fed back by forwarding. A taken request passes through the execute
// stage register and then the result register, from which it is offered.
// After reset, req_ready stays low while the data memory valid bits are cleared
// one word a cycle.
// A stalled result holds in the result register; one more word is taken into
// the execute stage, then req_ready drops until the result is taken.
module risc_subset_execute_unit #(
   parameter int DMEM_DEPTH = 4096,
   parameter int IMEM_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsx_pkg::FUNC_W-1:0]          req_func,
   input  logic [rsx_pkg::REG_IDX_W-1:0]       req_dest_reg,
   input  logic [rsx_pkg::REG_IDX_W-1:0]       req_src1_reg,
   input  logic [rsx_pkg::REG_IDX_W-1:0]       req_src2_reg,
   input  logic                                req_src2_is_imm,
   input  logic signed [rsx_pkg::DATA_W-1:0]   req_immediate,
   input  logic [rsx_pkg::ADDR_IN_W-1:0]       req_mem_address,
   input  logic [rsx_pkg::TARGET_IN_W-1:0]     req_branch_target,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rsx_pkg::PC_OUT_W-1:0]        rsp_next_pc,
   output logic                                rsp_branch_taken,
   output logic                                rsp_reg_written,
   output logic [rsx_pkg::REG_IDX_W-1:0]       rsp_written_reg,
   output logic [rsx_pkg::DATA_W-1:0]          rsp_written_value,
   output logic                                rsp_load_failed,
   output logic                                rsp_store_uninit_warning,
   output logic [rsx_pkg::COUNT_W-1:0]         rsp_opcode_count,
   output logic [rsx_pkg::COUNT_W-1:0]         rsp_instr_count
);

   localparam int AW = $clog2(DMEM_DEPTH);
   localparam int PW = $clog2(IMEM_DEPTH);

   // Handshake and stage control.
   logic accept;
   logic s1_fire;
   logic out_free;
   logic dm_busy;

   // Request word reduced into memory and program ranges.
   logic [AW-1:0] req_addr;
   logic [PW-1:0] req_target;
   logic [rsx_pkg::REG_IDX_W-1:0] rd_addr_b;

   // Execute stage registers.
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [rsx_pkg::FUNC_W-1:0]    s1_func_ff;
   logic [rsx_pkg::REG_IDX_W-1:0] s1_dest_ff;
   logic                          s1_use_imm_ff;
   logic [rsx_pkg::DATA_W-1:0]    s1_imm_ff;
   logic [AW-1:0]                 s1_addr_ff;
   logic [PW-1:0]                 s1_target_ff;

   // Architectural state kept in flops.
   logic [PW-1:0]               pc_ff;
   logic [PW-1:0]               pc_in;
   logic [rsx_pkg::COUNT_W-1:0] instr_cnt_ff;
   logic [rsx_pkg::COUNT_W-1:0] instr_cnt_in;
   logic [rsx_pkg::COUNT_W-1:0] op_cnt_ff [rsx_pkg::NUM_OPS];
   logic [rsx_pkg::COUNT_W-1:0] op_cnt_in [rsx_pkg::NUM_OPS];

   // Memory ports.
   rsx_pkg::rf_wr_type         rf_wr;
   logic [rsx_pkg::DATA_W-1:0] rf_data_a;
   logic [rsx_pkg::DATA_W-1:0] rf_data_b;
   logic                       dm_rd_valid;
   logic [rsx_pkg::DATA_W-1:0] dm_rd_data;
   logic                       dm_wr_en;

   // Execute stage values.
   logic [rsx_pkg::DATA_W-1:0]    op_a;
   logic [rsx_pkg::DATA_W-1:0]    op_b;
   logic [rsx_pkg::DATA_W-1:0]    mul_low;
   logic [rsx_pkg::DATA_W-1:0]    alu_result;
   logic                          ops_equal;
   logic [PW:0]                   pc_plus;
   logic [PW-1:0]                 seq_pc;
   logic                          is_instr;
   logic [rsx_pkg::OP_IDX_W-1:0]  op_idx;
   logic [rsx_pkg::COUNT_W-1:0]   op_cur;
   logic [rsx_pkg::COUNT_W-1:0]   op_inc;
   logic [rsx_pkg::COUNT_W-1:0]   instr_inc;
   logic [PW-1:0]                 next_pc;
   logic                          taken;
   logic                          rf_we;
   logic [rsx_pkg::REG_IDX_W-1:0] wreg;
   logic [rsx_pkg::DATA_W-1:0]    wval;
   logic                          lfail;
   logic                          swarn;
   logic                          dm_we;
   logic [rsx_pkg::DATA_W-1:0]    dm_wdata;

   // Result register.
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [rsx_pkg::PC_OUT_W-1:0]  rsp_next_pc_ff;
   logic                          rsp_taken_ff;
   logic                          rsp_wrote_ff;
   logic [rsx_pkg::REG_IDX_W-1:0] rsp_wreg_ff;
   logic [rsx_pkg::DATA_W-1:0]    rsp_wval_ff;
   logic                          rsp_lfail_ff;
   logic                          rsp_swarn_ff;
   logic [rsx_pkg::COUNT_W-1:0]   rsp_opc_ff;
   logic [rsx_pkg::COUNT_W-1:0]   rsp_icnt_ff;

   // Flow control: the execute stage moves when the result register is free.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !dm_busy && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   // Address and target wrap into the memory and program sizes.
   rsx_mod_const #(
      .IN_W    (rsx_pkg::ADDR_IN_W),
      .DIVISOR (DMEM_DEPTH),
      .OUT_W   (AW)
   ) u_addr_mod (
      .value     (req_mem_address),
      .remainder (req_addr)
   );

   rsx_mod_const #(
      .IN_W    (rsx_pkg::TARGET_IN_W),
      .DIVISOR (IMEM_DEPTH),
      .OUT_W   (PW)
   ) u_target_mod (
      .value     (req_branch_target),
      .remainder (req_target)
   );

   // A store reads the register it stores on the second port.
   assign rd_addr_b = (req_func == rsx_pkg::FN_SW) ? req_dest_reg : req_src2_reg;

   rsx_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_src1_reg),
      .rd_addr_b (rd_addr_b),
      .wr        (rf_wr),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b)
   );

   rsx_dmem #(
      .DEPTH (DMEM_DEPTH),
      .AW    (AW)
   ) u_dmem (
      .clock    (clock),
      .reset    (reset),
      .busy     (dm_busy),
      .rd_en    (accept),
      .rd_addr  (req_addr),
      .rd_valid (dm_rd_valid),
      .rd_data  (dm_rd_data),
      .wr_en    (dm_wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_data  (dm_wdata)
   );

   // Execute stage register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_func_ff    <= req_func;
         s1_dest_ff    <= req_dest_reg;
         s1_use_imm_ff <= req_src2_is_imm;
         s1_imm_ff     <= $unsigned(req_immediate);
         s1_addr_ff    <= req_addr;
         s1_target_ff  <= req_target;
      end
   end

   // Operands and arithmetic.
   assign op_a      = rf_data_a;
   assign op_b      = s1_use_imm_ff ? s1_imm_ff : rf_data_b;
   assign mul_low   = op_a * op_b;
   assign ops_equal = (op_a == op_b);

   always_comb begin
      case (s1_func_ff)
         rsx_pkg::FN_SUB:  alu_result = op_a - op_b;
         rsx_pkg::FN_MUL:  alu_result = mul_low;
         rsx_pkg::FN_ADDI: alu_result = op_a + s1_imm_ff;
         rsx_pkg::FN_SLT:  alu_result = rsx_pkg::DATA_W'($signed(op_a) < $signed(op_b));
         default:          alu_result = op_a + op_b;
      endcase
   end

   // Sequential program counter, wrapping at the program size.
   assign pc_plus = (PW + 1)'(pc_ff) + (PW + 1)'(1);
   assign seq_pc  = (pc_plus == (PW + 1)'(IMEM_DEPTH)) ? '0 : pc_plus[PW-1:0];

   // Instruction decode and effects.
   always_comb begin
      next_pc  = pc_ff;
      taken    = 1'b0;
      rf_we    = 1'b0;
      wreg     = '0;
      wval     = '0;
      lfail    = 1'b0;
      swarn    = 1'b0;
      dm_we    = 1'b0;
      dm_wdata = '0;
      unique case (s1_func_ff) inside
         rsx_pkg::FN_ADD, rsx_pkg::FN_SUB, rsx_pkg::FN_MUL, rsx_pkg::FN_ADDI,
         rsx_pkg::FN_SLT: begin
            wreg    = s1_dest_ff;
            wval    = alu_result;
            rf_we   = (s1_dest_ff != '0);
            next_pc = seq_pc;
         end
         rsx_pkg::FN_BEQ, rsx_pkg::FN_BNE: begin
            taken   = (s1_func_ff == rsx_pkg::FN_BEQ) ? ops_equal : !ops_equal;
            next_pc = taken ? s1_target_ff : seq_pc;
         end
         rsx_pkg::FN_LW: begin
            wreg    = s1_dest_ff;
            next_pc = seq_pc;
            if (dm_rd_valid) begin
               wval  = dm_rd_data;
               rf_we = (s1_dest_ff != '0);
            end else begin
               lfail = 1'b1;
            end
         end
         rsx_pkg::FN_SW: begin
            swarn    = !dm_rd_valid;
            dm_we    = 1'b1;
            dm_wdata = rf_data_b;
            next_pc  = seq_pc;
         end
         rsx_pkg::FN_J: begin
            taken   = 1'b1;
            next_pc = s1_target_ff;
         end
         rsx_pkg::FN_PRE_MEM: begin
            dm_we    = 1'b1;
            dm_wdata = s1_imm_ff;
         end
         rsx_pkg::FN_PRE_REG: begin
            wreg  = s1_dest_ff;
            wval  = s1_imm_ff;
            rf_we = (s1_dest_ff != '0);
         end
         default: begin
         end
      endcase
   end

   // Writes to the memories happen as the word leaves the execute stage.
   assign rf_wr.en   = s1_fire && rf_we;
   assign rf_wr.addr = s1_dest_ff;
   assign rf_wr.data = wval;
   assign dm_wr_en   = s1_fire && dm_we;

   // Saturating instruction counters.
   assign is_instr  = (s1_func_ff >= rsx_pkg::FN_ADD) && (s1_func_ff <= rsx_pkg::FN_J);
   assign op_idx    = rsx_pkg::OP_IDX_W'(s1_func_ff - rsx_pkg::FN_ADD);
   assign op_cur    = op_cnt_ff[op_idx];
   assign op_inc    = (op_cur == '1) ? op_cur : op_cur + rsx_pkg::COUNT_W'(1);
   assign instr_inc = (instr_cnt_ff == '1) ? instr_cnt_ff
                                           : instr_cnt_ff + rsx_pkg::COUNT_W'(1);

   always_comb begin
      pc_in        = pc_ff;
      instr_cnt_in = instr_cnt_ff;
      op_cnt_in    = op_cnt_ff;
      if (s1_fire && is_instr) begin
         pc_in             = next_pc;
         instr_cnt_in      = instr_inc;
         op_cnt_in[op_idx] = op_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         instr_cnt_ff <= '0;
         for (int i = 0; i < rsx_pkg::NUM_OPS; i++) begin
            op_cnt_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         instr_cnt_ff <= instr_cnt_in;
         op_cnt_ff    <= op_cnt_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire) begin
         rsp_next_pc_ff <= rsx_pkg::PC_OUT_W'(next_pc);
         rsp_taken_ff   <= taken;
         rsp_wrote_ff   <= rf_we;
         rsp_wreg_ff    <= wreg;
         rsp_wval_ff    <= wval;
         rsp_lfail_ff   <= lfail;
         rsp_swarn_ff   <= swarn;
         rsp_opc_ff     <= is_instr ? op_inc : '0;
         rsp_icnt_ff    <= is_instr ? instr_inc : instr_cnt_ff;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_next_pc              = rsp_next_pc_ff;
   assign rsp_branch_taken         = rsp_taken_ff;
   assign rsp_reg_written          = rsp_wrote_ff;
   assign rsp_written_reg          = rsp_wreg_ff;
   assign rsp_written_value        = rsp_wval_ff;
   assign rsp_load_failed          = rsp_lfail_ff;
   assign rsp_store_uninit_warning = rsp_swarn_ff;
   assign rsp_opcode_count         = rsp_opc_ff;
   assign rsp_instr_count          = rsp_icnt_ff;

endmodule

// File: rtl/rsx_checker.sv
// Port checker of the execute unit and its bind to the top level.
`include "risc_subset_execute_unit_assert.svh"

module rsx_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rsx_pkg::PC_OUT_W-1:0]        rsp_next_pc,
   input logic [rsx_pkg::DATA_W-1:0]          rsp_written_value,
   input logic [rsx_pkg::COUNT_W-1:0]         rsp_opcode_count,
   input logic [rsx_pkg::COUNT_W-1:0]         rsp_instr_count
);

   // A stalled result word stays offered.
   `RSX_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "Result word dropped while stalled.")

   // A stalled result word keeps its next PC, written value and opcode count.
   `RSX_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_next_pc) && $stable(rsp_written_value) && $stable(rsp_opcode_count), "Result word changed while stalled.")

   // The total count never goes back between back-to-back results.
   `RSX_ASSERT(a_count_order, clock, reset, (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready) |-> rsp_instr_count >= $past(rsp_instr_count), "Instruction count went backwards.")

   // Reset empties the result register and starts the memory clearing pass.
   `RSX_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && !req_ready, "Block not idle after reset.")

endmodule

bind risc_subset_execute_unit rsx_checker u_rsx_checker (.*);
